// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the timer table core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ttw_pkg.sv =====
// ----------------------------------------------------------------------------
// ttw_pkg
// Types and codes of the timer table: command and result items, kinds,
// event and status codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttw_pkg;

    localparam int TICK_W  = 64;
    localparam int DELAY_W = 32;
    localparam int SLOT_W  = 16;
    localparam int CNT_W   = 6;

    // Command kinds
    localparam logic [1:0] KIND_ADD_ONE = 2'd0;
    localparam logic [1:0] KIND_ADD_PER = 2'd1;
    localparam logic [1:0] KIND_CANCEL  = 2'd2;
    localparam logic [1:0] KIND_TICK    = 2'd3;

    // Result event codes
    localparam logic [1:0] EV_ACK     = 2'd0;
    localparam logic [1:0] EV_FIRED   = 2'd1;
    localparam logic [1:0] EV_SUMMARY = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_NOMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DELAY_W-1:0] delay_ms;
        logic [4:0]         handle_index;
        logic [7:0]         handle_generation;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [1:0]       status;
        logic [4:0]       entry_index;
        logic [7:0]       entry_generation;
        logic [CNT_W-1:0] fired_count;
        logic [CNT_W-1:0] pending_count;
        logic             last;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_FULL,
        ST_DIV,
        ST_ADD_WR,
        ST_CANCEL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SUMMARY
    } t_state;

endpackage

// ===== rtl/ttw_chan_if.sv =====
// ----------------------------------------------------------------------------
// ttw_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ttw_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ttw_div.sv =====
// ----------------------------------------------------------------------------
// ttw_div
// Bit-serial restoring divider: ceiling of delay / slot, at least 1.
// One quotient bit per cycle; the result holds until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttw_div
    import ttw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DELAY_W-1:0] i_num,
    input  logic [SLOT_W-1:0]  i_den,
    output logic               o_done,
    output logic [DELAY_W-1:0] o_ticks
);

    localparam int STEP_W = $clog2(DELAY_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0]  r_den, n_den;
    logic [SLOT_W:0]    r_rem, n_rem;
    logic [DELAY_W-1:0] r_q, n_q;

    logic [SLOT_W:0]    rem_sh;
    logic               fits;

    // One restoring step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_rem  = r_rem;
        n_q    = r_q;
        rem_sh = {r_rem[SLOT_W-1:0], r_q[DELAY_W-1]};
        fits   = rem_sh >= {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
            n_den  = i_den;
            n_rem  = '0;
            n_q    = i_num;
        end else if (r_busy) begin
            n_rem = fits ? rem_sh - {1'b0, r_den} : rem_sh;
            n_q   = {r_q[DELAY_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == STEP_W'(DELAY_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    // Round up on a nonzero remainder; a zero delay still takes one tick
    always_comb begin
        if (r_q == '0 && r_rem == '0) begin
            o_ticks = DELAY_W'(1);
        end else begin
            o_ticks = r_q + DELAY_W'(r_rem != '0);
        end
    end

    assign o_done = r_done;

endmodule

// ===== rtl/timer_table_with_tick_expiry_core.sv =====
// A table of MAX_TIMERS one-shot or periodic timers driven by tick commands.
// Every command is handled on its own; the command channel is ready only
// while the sequencer idles. An add searches for the lowest free entry at
// one entry per cycle, then converts the delay to ticks in a bit-serial
// divider and writes the entry. A tick visits each entry in turn (read of
// the expiry memory, then compare and update) and waits while the result
// channel stalls. Results leave through one output register, so a new
// command is taken while the last result still waits.
// ----------------------------------------------------------------------------
// timer_table_with_tick_expiry_core
// Timer table with tick-driven expiry, add/cancel handles and fire events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timer_table_with_tick_expiry_core
    import ttw_pkg::*;
#(
    parameter int MAX_TIMERS = 32,
    parameter int GEN_BITS   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SLOT_W-1:0] i_cfg_wdata,
    ttw_chan_if.sink          i_cmd,
    ttw_chan_if.source        o_res
);

    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

    // Control and state registers
    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_in_range, n_in_range;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [MAX_TIMERS-1:0] r_active, n_active;
    logic [GEN_BITS-1:0]   r_gen [MAX_TIMERS];
    logic [GEN_BITS-1:0]   n_gen [MAX_TIMERS];
    logic [CNT_W-1:0]      r_total, n_total;
    logic [CNT_W-1:0]      r_fired, n_fired;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_ov;
    t_res                  r_out, n_out;

    // Expiry and period memories, one port each
    logic [TICK_W-1:0]     r_exp_mem [MAX_TIMERS];
    logic [DELAY_W-1:0]    r_per_mem [MAX_TIMERS];
    logic [TICK_W-1:0]     r_rd_exp;
    logic [DELAY_W-1:0]    r_rd_per;
    logic                  exp_we, per_we;
    logic [TICK_W-1:0]     exp_wdata;
    logic [DELAY_W-1:0]    per_wdata;

    logic                  out_free, emit;
    logic [GEN_BITS-1:0]   gen_sel, gen_inc;
    logic [31:0]           gen_sel32, gen_inc32;
    logic                  hit, last_idx;

    logic                  div_start, div_done;
    logic [DELAY_W-1:0]    div_ticks;
    logic [SLOT_W-1:0]     slot_eff;

    assign out_free    = !r_ov || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    assign gen_sel   = r_gen[r_idx];
    assign gen_inc   = gen_sel + 1'b1;
    assign gen_sel32 = 32'(gen_sel);
    assign gen_inc32 = 32'(gen_inc);
    assign hit       = r_active[r_idx] && (r_rd_exp == r_tick);
    assign last_idx  = (r_idx == IW'(MAX_TIMERS - 1));
    assign slot_eff  = (r_slot == '0) ? SLOT_W'(1) : r_slot;

    // Delay to tick conversion
    ttw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_cmd.delay_ms),
        .i_den   (slot_eff),
        .o_done  (div_done),
        .o_ticks (div_ticks)
    );

    // Sequencer: next state, table updates and result item
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_in_range = r_in_range;
        n_tick     = r_tick;
        n_active   = r_active;
        n_gen      = r_gen;
        n_total    = r_total;
        n_fired    = r_fired;
        n_out      = r_out;
        emit       = 1'b0;
        div_start  = 1'b0;
        exp_we     = 1'b0;
        per_we     = 1'b0;
        exp_wdata  = r_rd_exp + TICK_W'(r_rd_per);
        per_wdata  = (r_cmd.kind == KIND_ADD_PER) ? div_ticks : '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd = i_cmd.data;
                    n_idx = '0;
                    unique case (i_cmd.data.kind)
                        KIND_ADD_ONE, KIND_ADD_PER: begin
                            n_state = ST_FIND;
                        end
                        KIND_CANCEL: begin
                            n_idx      = IW'(i_cmd.data.handle_index);
                            n_in_range = 32'(i_cmd.data.handle_index) < 32'(MAX_TIMERS);
                            n_state    = ST_CANCEL;
                        end
                        KIND_TICK: begin
                            n_tick  = r_tick + 1'b1;
                            n_fired = '0;
                            n_state = ST_SCAN_RD;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            // Lowest free entry, one per cycle
            ST_FIND: begin
                if (!r_active[r_idx]) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else if (last_idx) begin
                    n_state = ST_FULL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_FULL: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    n_out.event_res        = EV_ACK;
                    n_out.status           = STAT_FULL;
                    n_out.entry_index      = '0;
                    n_out.entry_generation = '0;
                    n_out.fired_count      = '0;
                    n_out.pending_count    = r_total;
                    n_out.last             = 1'b1;
                    n_state                = ST_IDLE;
                end
            end

            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_ADD_WR;
                end
            end

            // Arm the entry with a bumped generation
            ST_ADD_WR: begin
                if (out_free) begin
                    exp_we                 = 1'b1;
                    exp_wdata              = r_tick + TICK_W'(div_ticks);
                    per_we                 = 1'b1;
                    n_gen[r_idx]           = gen_inc;
                    n_active[r_idx]        = 1'b1;
                    n_total                = r_total + 1'b1;
                    emit                   = 1'b1;
                    n_out.event_res        = EV_ACK;
                    n_out.status           = STAT_OK;
                    n_out.entry_index      = 5'(r_idx);
                    n_out.entry_generation = gen_inc32[7:0];
                    n_out.fired_count      = '0;
                    n_out.pending_count    = r_total + 1'b1;
                    n_out.last             = 1'b1;
                    n_state                = ST_IDLE;
                end
            end

            ST_CANCEL: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    n_out.event_res        = EV_ACK;
                    n_out.status           = STAT_NOMATCH;
                    n_out.entry_index      = r_cmd.handle_index;
                    n_out.entry_generation = r_cmd.handle_generation;
                    n_out.fired_count      = '0;
                    n_out.pending_count    = r_total;
                    n_out.last             = 1'b1;
                    if (r_in_range && r_active[r_idx] &&
                        gen_sel32[7:0] == r_cmd.handle_generation) begin
                        n_active[r_idx]     = 1'b0;
                        n_total             = r_total - 1'b1;
                        n_out.status        = STAT_OK;
                        n_out.pending_count = r_total - 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end

            // Memory read latency
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end

            // Compare expiry, fire, re-arm or free
            ST_SCAN_CHK: begin
                if (!hit || out_free) begin
                    if (hit) begin
                        emit                   = 1'b1;
                        n_fired                = r_fired + 1'b1;
                        n_out.event_res        = EV_FIRED;
                        n_out.status           = STAT_OK;
                        n_out.entry_index      = 5'(r_idx);
                        n_out.entry_generation = gen_sel32[7:0];
                        n_out.fired_count      = '0;
                        n_out.pending_count    = r_total;
                        n_out.last             = 1'b0;
                        if (r_rd_per != '0) begin
                            exp_we = 1'b1;
                        end else begin
                            n_active[r_idx]     = 1'b0;
                            n_total             = r_total - 1'b1;
                            n_out.pending_count = r_total - 1'b1;
                        end
                    end
                    if (last_idx) begin
                        n_state = ST_SUMMARY;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_SCAN_RD;
                    end
                end
            end

            ST_SUMMARY: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    n_out.event_res        = EV_SUMMARY;
                    n_out.status           = STAT_OK;
                    n_out.entry_index      = '0;
                    n_out.entry_generation = '0;
                    n_out.fired_count      = r_fired;
                    n_out.pending_count    = r_total;
                    n_out.last             = 1'b1;
                    n_state                = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Table control state, tick counter, slot length, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_active <= '0;
            r_total  <= '0;
            r_fired  <= '0;
            r_slot   <= SLOT_W'(1);
            r_ov     <= 1'b0;
            for (int k = 0; k < MAX_TIMERS; k++) begin
                r_gen[k] <= '0;
            end
        end else begin
            r_tick   <= n_tick;
            r_active <= n_active;
            r_total  <= n_total;
            r_fired  <= n_fired;
            r_gen    <= n_gen;
            if (i_cfg_we) begin
                r_slot <= i_cfg_wdata;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_in_range <= n_in_range;
        if (emit) begin
            r_out <= n_out;
        end
    end

    // Expiry and period memories with registered read
    always_ff @(posedge i_clk) begin
        if (exp_we) begin
            r_exp_mem[r_idx] <= exp_wdata;
        end
        if (per_we) begin
            r_per_mem[r_idx] <= per_wdata;
        end
        r_rd_exp <= r_exp_mem[r_idx];
        r_rd_per <= r_per_mem[r_idx];
    end

    // Checks
    `ASSERT_IMP(a_total_matches, i_clk, i_rst_n, 1'b1,
        $countones(r_active) == int'(r_total), "active count out of step")
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready,
        !i_cmd.ready, "command taken while a command is in work")
    `ASSERT_IMP(a_summary_last, i_clk, i_rst_n,
        o_res.valid && o_res.data.event_res == EV_SUMMARY,
        o_res.data.last, "tick summary without last flag")
    `ASSERT_IMP(a_fire_not_last, i_clk, i_rst_n,
        o_res.valid && o_res.data.event_res == EV_FIRED,
        !o_res.data.last && o_res.data.status == STAT_OK,
        "fire event with last flag or bad status")

endmodule

// ===== test/timer_table_checker.sv =====
// ----------------------------------------------------------------------------
// timer_table_checker
// Watches the slot-length write port and both channels of the timer table.
// Keeps its own copy of the table, predicts the results of every command
// transfer and compares each result transfer field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_table_checker
    import ttw_pkg::*;
#(
    parameter int MAX_TIMERS = 32,
    parameter int GEN_BITS   = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [SLOT_W-1:0]          i_cfg_wdata,
    input  logic                       i_cmd_valid,
    input  logic                       i_cmd_ready,
    input  t_cmd                       i_cmd_data,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  t_res                       i_res_data,
    output int                         o_fail_count,
    output int                         o_outstanding,
    output logic [MAX_TIMERS-1:0]      o_live_mask,
    output logic [MAX_TIMERS-1:0][7:0] o_gen_table
);

    // Shadow of the timer table
    logic [SLOT_W-1:0]   slot_ms;
    logic [TICK_W-1:0]   tick_count;
    logic [MAX_TIMERS-1:0] live;
    logic [TICK_W-1:0]   due_tick    [MAX_TIMERS];
    logic [DELAY_W-1:0]  rearm_ticks [MAX_TIMERS];
    logic [GEN_BITS-1:0] gen         [MAX_TIMERS];
    int                  live_total;

    // Results predicted but not yet seen on the result channel
    t_res awaited_results [$];

    task automatic clear_table();
        slot_ms    = SLOT_W'(1);
        tick_count = '0;
        live       = '0;
        live_total = 0;
        for (int i = 0; i < MAX_TIMERS; i++) begin
            due_tick[i]    = '0;
            rearm_ticks[i] = '0;
            gen[i]         = '0;
        end
        awaited_results.delete();
    endtask

    // Ceiling division by the slot length, zero slot counts as 1 ms
    function automatic logic [TICK_W-1:0] delay_in_ticks(input logic [DELAY_W-1:0] d);
        logic [TICK_W-1:0] s;
        s = (slot_ms == '0) ? 64'd1 : 64'(slot_ms);
        if (d == '0) return 64'd1;
        return (64'(d) + s - 64'd1) / s;
    endfunction

    task automatic await_result(input logic [1:0] ev, input logic [1:0] st,
                                input logic [4:0] idx, input logic [7:0] g,
                                input logic [CNT_W-1:0] fired, input logic last);
        t_res r;
        r.event_res        = ev;
        r.status           = st;
        r.entry_index      = idx;
        r.entry_generation = g;
        r.fired_count      = fired;
        r.pending_count    = CNT_W'(live_total);
        r.last             = last;
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic predict_command(input t_cmd c);
        int                free_idx;
        int                fired;
        int                h;
        logic [TICK_W-1:0] ticks;
        logic [1:0]        st;
        free_idx = -1;
        fired    = 0;
        h        = int'(c.handle_index);
        case (c.kind)
            KIND_ADD_ONE, KIND_ADD_PER: begin
                for (int i = 0; i < MAX_TIMERS; i++)
                    if (!live[i] && free_idx < 0) free_idx = i;
                if (free_idx < 0) begin
                    await_result(EV_ACK, STAT_FULL, '0, '0, '0, 1'b1);
                end else begin
                    ticks                 = delay_in_ticks(c.delay_ms);
                    gen[free_idx]         = gen[free_idx] + 1'b1;
                    due_tick[free_idx]    = tick_count + ticks;
                    rearm_ticks[free_idx] = (c.kind == KIND_ADD_PER) ? ticks[DELAY_W-1:0] : '0;
                    live[free_idx]        = 1'b1;
                    live_total++;
                    await_result(EV_ACK, STAT_OK, 5'(free_idx), 8'(gen[free_idx]), '0, 1'b1);
                end
            end
            KIND_CANCEL: begin
                st = STAT_NOMATCH;
                if (h < MAX_TIMERS && live[h] && 8'(gen[h]) == c.handle_generation) begin
                    live[h] = 1'b0;
                    live_total--;
                    st = STAT_OK;
                end
                await_result(EV_ACK, st, c.handle_index, c.handle_generation, '0, 1'b1);
            end
            default: begin
                // Tick: fire every entry due now, lowest index first
                tick_count = tick_count + 64'd1;
                for (int i = 0; i < MAX_TIMERS; i++) begin
                    if (live[i] && due_tick[i] == tick_count) begin
                        fired++;
                        if (rearm_ticks[i] != '0) begin
                            due_tick[i] = due_tick[i] + 64'(rearm_ticks[i]);
                        end else begin
                            live[i] = 1'b0;
                            live_total--;
                        end
                        await_result(EV_FIRED, STAT_OK, 5'(i), 8'(gen[i]), '0, 1'b0);
                    end
                end
                await_result(EV_SUMMARY, STAT_OK, '0, '0, CNT_W'(fired), 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        if (awaited_results.size() == 0) begin
            $error("result with nothing awaited: event_res %0d, entry_index %0d",
                   got.event_res, got.entry_index);
            o_fail_count++;
        end else begin
            want = awaited_results.pop_front();
            check_field("event_res", 8'(want.event_res), 8'(got.event_res));
            check_field("status", 8'(want.status), 8'(got.status));
            check_field("entry_index", 8'(want.entry_index), 8'(got.entry_index));
            check_field("entry_generation", want.entry_generation, got.entry_generation);
            check_field("fired_count", 8'(want.fired_count), 8'(got.fired_count));
            check_field("pending_count", 8'(want.pending_count), 8'(got.pending_count));
            check_field("last", 8'(want.last), 8'(got.last));
        end
    endtask

    // Sample every transfer at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
        end else begin
            if (i_cfg_we) slot_ms = i_cfg_wdata;
            if (i_cmd_valid && i_cmd_ready) predict_command(i_cmd_data);
            if (i_res_valid && i_res_ready) check_result(i_res_data);
        end
        o_outstanding <= awaited_results.size();
        o_live_mask   <= live;
        for (int i = 0; i < MAX_TIMERS; i++) o_gen_table[i] <= 8'(gen[i]);
    end

endmodule

// ===== test/timer_table_with_tick_expiry_core_test.sv =====
// ----------------------------------------------------------------------------
// timer_table_with_tick_expiry_core_test
// Drives the timer table with adds, cancels and ticks under several slot
// lengths, with random gaps on both channels, and reports the verdict from
// the failure count of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_table_with_tick_expiry_core_test;
    import ttw_pkg::*;

    localparam int TIMERS      = 32;
    localparam int CYCLE_LIMIT = 1000000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SLOT_W-1:0] cfg_wdata;

    int                     fail_count;
    int                     outstanding;
    logic [TIMERS-1:0]      live_mask;
    logic [TIMERS-1:0][7:0] gen_table;

    logic [SLOT_W-1:0] slot_now;
    bit                calm;

    ttw_chan_if #(.t_payload(t_cmd)) cmd_ch ();
    ttw_chan_if #(.t_payload(t_res)) res_ch ();

    timer_table_with_tick_expiry_core #(
        .MAX_TIMERS(TIMERS),
        .GEN_BITS  (8)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    timer_table_checker #(
        .MAX_TIMERS(TIMERS),
        .GEN_BITS  (8)
    ) watch (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_cmd_valid  (cmd_ch.valid),
        .i_cmd_ready  (cmd_ch.ready),
        .i_cmd_data   (cmd_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding),
        .o_live_mask  (live_mask),
        .o_gen_table  (gen_table)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Result sink: random stall before each transfer
    initial begin : res_sink
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            @(negedge clk);
        end
    end

    function automatic t_cmd make_cmd(input logic [1:0] kind, input logic [31:0] delay,
                                      input logic [4:0] idx, input logic [7:0] g);
        t_cmd c;
        c.kind              = kind;
        c.delay_ms          = delay;
        c.handle_index      = idx;
        c.handle_generation = g;
        return c;
    endfunction

    // Delays mostly a few slots long so timers fire within the run
    function automatic logic [31:0] pick_delay();
        int unsigned s;
        s = (slot_now == '0) ? 1 : 32'(slot_now);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF;
            3:       return s * $urandom_range(1, 4);
            4:       return s * $urandom_range(0, 3) + 1;
            default: return $urandom_range(0, 4 * s);
        endcase
    endfunction

    // Aimed cancels hit a live entry, sometimes with a stale generation
    function automatic t_cmd pick_cancel(input bit aimed);
        t_cmd c;
        int   start;
        int   idx;
        c     = make_cmd(KIND_CANCEL, $urandom, 5'($urandom), 8'($urandom));
        start = $urandom_range(0, TIMERS - 1);
        idx   = -1;
        if (aimed) begin
            for (int k = 0; k < TIMERS; k++)
                if (idx < 0 && live_mask[(start + k) % TIMERS]) idx = (start + k) % TIMERS;
            if (idx >= 0) begin
                c.handle_index      = 5'(idx);
                c.handle_generation = gen_table[idx];
                if ($urandom_range(0, 7) == 0) c.handle_generation = gen_table[idx] - 8'd1;
            end
        end
        return c;
    endfunction

    // One command transfer; entered and left at a falling edge
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.data  = c;
        do @(posedge clk); while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_slot(input logic [SLOT_W-1:0] v);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        slot_now  = v;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic run_mix(input int n, input int add_pct, input int tick_pct);
        int roll;
        for (int k = 0; k < n; k++) begin
            if (k % 16 == 0) calm = ($urandom_range(0, 2) == 0);
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                send_cmd(make_cmd($urandom_range(0, 1) ? KIND_ADD_PER : KIND_ADD_ONE,
                                  pick_delay(), 5'($urandom), 8'($urandom)));
            else if (roll < add_pct + tick_pct)
                send_cmd(make_cmd(KIND_TICK, $urandom, 5'($urandom), 8'($urandom)));
            else
                send_cmd(pick_cancel($urandom_range(0, 3) != 0));
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [7:0] g;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        slot_now     = SLOT_W'(1);
        calm         = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero and maximum delays, periodic re-arm, cancel cases
        write_slot(1);
        send_cmd(make_cmd(KIND_ADD_ONE, 32'd0, '0, '0));
        send_cmd(make_cmd(KIND_ADD_PER, 32'd1, '0, '0));
        send_cmd(make_cmd(KIND_ADD_ONE, 32'hFFFF_FFFF, '0, '0));
        send_cmd(make_cmd(KIND_ADD_PER, 32'd2, '0, '0));
        send_cmd(make_cmd(KIND_TICK, '0, '0, '0));
        send_cmd(make_cmd(KIND_TICK, '0, '0, '0));
        g = gen_table[2];
        send_cmd(make_cmd(KIND_CANCEL, '0, 5'd2, g + 8'd1));
        send_cmd(make_cmd(KIND_CANCEL, '0, 5'd5, 8'd0));
        send_cmd(make_cmd(KIND_CANCEL, '0, 5'd2, g));
        send_cmd(make_cmd(KIND_CANCEL, '0, 5'd2, g));
        send_cmd(make_cmd(KIND_CANCEL, '0, 5'd31, 8'd255));
        send_cmd(make_cmd(KIND_ADD_ONE, 32'd1, '0, '0));
        send_cmd(make_cmd(KIND_TICK, '0, '0, '0));
        // Zero slot length acts as 1 ms
        write_slot(0);
        send_cmd(make_cmd(KIND_ADD_ONE, 32'd5, '0, '0));
        send_cmd(make_cmd(KIND_ADD_PER, 32'd3, '0, '0));
        send_cmd(make_cmd(KIND_TICK, '0, '0, '0));
        // Widest slot: rounding up at exact multiples
        write_slot(16'hFFFF);
        send_cmd(make_cmd(KIND_ADD_ONE, 32'd65535, '0, '0));
        send_cmd(make_cmd(KIND_ADD_ONE, 32'd65536, '0, '0));
        send_cmd(make_cmd(KIND_ADD_PER, 32'd0, '0, '0));
        send_cmd(make_cmd(KIND_ADD_PER, 32'hFFFF_FFFF, '0, '0));
        send_cmd(make_cmd(KIND_TICK, '0, '0, '0));
        send_cmd(make_cmd(KIND_TICK, '0, '0, '0));

        // Random mixes under several slot lengths
        write_slot(1);
        run_mix(24, 40, 35);
        write_slot(3);
        run_mix(24, 40, 35);
        write_slot(0);
        run_mix(24, 40, 35);
        write_slot(16'($urandom_range(1, 65535)));
        run_mix(24, 40, 35);

        // Fill the table, overflow it, then fire a large batch in one tick
        write_slot(16'hFFFF);
        run_mix(8, 80, 5);
        while (!(&live_mask))
            send_cmd(make_cmd($urandom_range(0, 1) ? KIND_ADD_PER : KIND_ADD_ONE,
                              32'($urandom_range(0, 65535)), 5'($urandom), 8'($urandom)));
        send_cmd(make_cmd(KIND_ADD_ONE, $urandom, 5'($urandom), 8'($urandom)));
        send_cmd(make_cmd(KIND_ADD_PER, $urandom, 5'($urandom), 8'($urandom)));
        send_cmd(make_cmd(KIND_TICK, $urandom, 5'($urandom), 8'($urandom)));

        // Free and reuse entry 0 a few times
        wait_drained();
        for (int k = 0; k < 6; k++) begin
            if (k % 3 == 0) calm = ($urandom_range(0, 2) == 0);
            if (live_mask[0]) send_cmd(make_cmd(KIND_CANCEL, $urandom, 5'd0, gen_table[0]));
            send_cmd(make_cmd(KIND_ADD_ONE, $urandom, 5'($urandom), 8'($urandom)));
        end
        send_cmd(pick_cancel(1'b1));
        send_cmd(make_cmd(KIND_TICK, '0, '0, '0));

        // Drain, then allow time for any stray result
        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ttw_pkg.sv
rtl/ttw_chan_if.sv
rtl/ttw_div.sv
rtl/timer_table_with_tick_expiry_core.sv
test/timer_table_checker.sv
test/timer_table_with_tick_expiry_core_test.sv
